@@ rtl/udvmod_pkg.sv @@
// Shared constants for the UDVM operand decoder: memory size and item function codes.
package udvmod_pkg;

	// Default size of the byte memory; a power of two between 256 and 65536.
	localparam int unsigned MEM_BYTES_DEF = 65536;

	localparam logic [2:0] FUNC_LITERAL   = 3'd0;
	localparam logic [2:0] FUNC_REFERENCE = 3'd1;
	localparam logic [2:0] FUNC_MULTITYPE = 3'd2;
	localparam logic [2:0] FUNC_ADDRESS   = 3'd3;
	localparam logic [2:0] FUNC_WRITE     = 3'd4;

endpackage

@@ rtl/udvmod_mem.sv @@
// Single-port byte memory with a registered read port.
module udvmod_mem #(
	parameter int unsigned MEM_BYTES = udvmod_pkg::MEM_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MEM_BYTES)-1:0] addr,
	input  logic [7:0]                   wdata,
	output logic [7:0]                   rdata
);
	import udvmod_pkg::*;

	logic [7:0] mem_q [MEM_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/udvm_operand_decoder_unit.sv @@
// UDVM operand decoder: byte memory, operand decode sequencer and result register.
//
// Input words arrive on in_valid/in_stall; one result word leaves on out_valid/out_stall
// for every input word. A write word (func 4) stores write_byte at write_address and
// returns a zero value with the pointer unchanged; so do unused codes. Other words decode
// one operand whose bytes start at exec_pointer in the internal memory.
// All memory traffic goes through one single-port memory with a registered read, so
// each operand byte or indirect byte is a separate memory read. Write words and unused
// codes go straight to the final state; operands also pass through the byte states,
// and the forms that fetch a word and then the word it points to pass through them
// twice. in_stall is high until the result has been loaded into the output register.
// The output register holds its word while out_stall is high; the sequencer waits
// in its final state until the register is free.
// Reset clears the sequencer and the output valid flag. Memory contents are not
// cleared; operands must only read bytes that were written before.
module udvm_operand_decoder_unit #(
	parameter int unsigned MEM_BYTES = udvmod_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] exec_pointer,
	input  logic [15:0] instr_address,
	input  logic [15:0] write_address,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] decoded_value,
	output logic [15:0] next_pointer,
	output logic        invalid_operand
);
	import udvmod_pkg::*;

	localparam int unsigned AW = $clog2(MEM_BYTES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_B0   = 3'd1;
	localparam logic [2:0] S_HI   = 3'd2;
	localparam logic [2:0] S_LO   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [1:0] FIN_WORD = 2'd0;
	localparam logic [1:0] FIN_LIT  = 2'd1;
	localparam logic [1:0] FIN_F12  = 2'd2;
	localparam logic [1:0] FIN_M13  = 2'd3;

	localparam logic [1:0] IND_NONE = 2'd0;
	localparam logic [1:0] IND_FULL = 2'd1;
	localparam logic [1:0] IND_M13  = 2'd2;

	logic [2:0]    state_q, state_d;
	logic [2:0]    func_q;
	logic [15:0]   ep_q, ia_q;
	logic [15:0]   w_q, w_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [1:0]    len_q, len_d;
	logic [1:0]    fin_q, fin_d;
	logic [1:0]    ind_q, ind_d;
	logic          bad_q, bad_d;

	logic          out_valid_q;
	logic [15:0]   value_q, np_q;
	logic          inv_q;

	logic          accept;
	logic          out_free;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    rdata;
	logic [15:0]   word;
	logic [15:0]   ind_addr;
	logic [15:0]   raw_value;
	logic [15:0]   final_value;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign mem_we   = accept && (func == FUNC_WRITE);

	assign word     = {w_q[15:8], rdata};
	assign ind_addr = (ind_q == IND_M13) ? {3'b000, word[12:0]} : word;

	udvmod_mem #(
		.MEM_BYTES(MEM_BYTES)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(write_byte),
		.rdata(rdata)
	);

	// Sequencer: picks the next memory address and assembles the operand word.
	always_comb begin
		state_d  = state_q;
		w_d      = w_q;
		addr_d   = addr_q;
		len_d    = len_q;
		fin_d    = fin_q;
		ind_d    = ind_q;
		bad_d    = bad_q;
		mem_addr = addr_q;
		case (state_q)
			S_IDLE: begin
				mem_addr = (func == FUNC_WRITE) ? AW'(write_address) : AW'(exec_pointer);
				if (accept) begin
					w_d   = '0;
					len_d = 2'd0;
					fin_d = FIN_WORD;
					ind_d = IND_NONE;
					bad_d = 1'b0;
					if (func < FUNC_WRITE) begin
						state_d = S_B0;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_B0: begin
				mem_addr = AW'(ep_q) + AW'(1);
				addr_d   = AW'(ep_q) + AW'(1);
				if (func_q == FUNC_LITERAL || func_q == FUNC_REFERENCE) begin
					if (rdata[7:6] == 2'b11) begin
						len_d   = 2'd3;
						state_d = S_HI;
					end else if (rdata[7]) begin
						w_d[15:8] = rdata;
						len_d     = 2'd2;
						fin_d     = FIN_LIT;
						state_d   = S_LO;
					end else begin
						w_d     = {9'd0, rdata[6:0]};
						len_d   = 2'd1;
						fin_d   = FIN_LIT;
						state_d = S_FIN;
					end
				end else begin
					case (rdata) inside
						[8'h00:8'h3f]: begin
							w_d     = {8'd0, rdata};
							len_d   = 2'd1;
							state_d = S_FIN;
						end
						[8'h40:8'h7f]: begin
							mem_addr = AW'({rdata[5:0], 1'b0});
							addr_d   = AW'({rdata[5:0], 1'b0});
							len_d    = 2'd1;
							state_d  = S_HI;
						end
						8'h80: begin
							len_d   = 2'd3;
							state_d = S_HI;
						end
						8'h81: begin
							len_d   = 2'd3;
							ind_d   = IND_FULL;
							state_d = S_HI;
						end
						[8'h82:8'h85]: begin
							bad_d   = 1'b1;
							state_d = S_FIN;
						end
						[8'h86:8'h87]: begin
							w_d     = 16'h0040 << rdata[0];
							len_d   = 2'd1;
							state_d = S_FIN;
						end
						[8'h88:8'h8f]: begin
							w_d     = 16'h0100 << rdata[2:0];
							len_d   = 2'd1;
							state_d = S_FIN;
						end
						[8'h90:8'h9f]: begin
							w_d[15:8] = rdata;
							len_d     = 2'd2;
							fin_d     = FIN_F12;
							state_d   = S_LO;
						end
						[8'ha0:8'hbf]: begin
							w_d[15:8] = rdata;
							len_d     = 2'd2;
							fin_d     = FIN_M13;
							state_d   = S_LO;
						end
						[8'hc0:8'hdf]: begin
							w_d[15:8] = rdata;
							len_d     = 2'd2;
							ind_d     = IND_M13;
							state_d   = S_LO;
						end
						default: begin
							w_d     = {11'h7ff, rdata[4:0]};
							len_d   = 2'd1;
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_HI: begin
				w_d[15:8] = rdata;
				mem_addr  = addr_q + AW'(1);
				state_d   = S_LO;
			end
			S_LO: begin
				mem_addr = AW'(ind_addr);
				if (ind_q != IND_NONE) begin
					// The word just read is itself the address of the operand word.
					addr_d  = AW'(ind_addr);
					ind_d   = IND_NONE;
					state_d = S_HI;
				end else begin
					w_d     = word;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		case (fin_q)
			FIN_LIT: begin
				if (func_q == FUNC_REFERENCE) begin
					raw_value = {1'b0, w_q[13:0], 1'b0};
				end else begin
					raw_value = {2'b00, w_q[13:0]};
				end
			end
			FIN_F12: raw_value = {4'hf, w_q[11:0]};
			FIN_M13: raw_value = {3'b000, w_q[12:0]};
			default: raw_value = w_q;
		endcase
		if (func_q == FUNC_ADDRESS && !bad_q) begin
			final_value = raw_value + ia_q;
		end else begin
			final_value = raw_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			ep_q   <= exec_pointer;
			ia_q   <= instr_address;
		end
		w_q    <= w_d;
		addr_q <= addr_d;
		len_q  <= len_d;
		fin_q  <= fin_d;
		ind_q  <= ind_d;
		bad_q  <= bad_d;
		if (state_q == S_FIN && out_free) begin
			value_q <= final_value;
			np_q    <= ep_q + {14'd0, len_q};
			inv_q   <= bad_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign decoded_value   = value_q;
	assign next_pointer    = np_q;
	assign invalid_operand = inv_q;

	// An invalid operand never carries a value.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_operand |-> decoded_value == 16'd0)
		else $error("invalid operand with nonzero value");

	// An accepted word always starts either a decode or a direct finish.
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_B0 || state_q == S_FIN))
		else $error("accepted word did not start the sequencer");

	// The low byte of a word is only read right after its high byte is known.
	a_lo_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LO |-> ($past(state_q) == S_HI || $past(state_q) == S_B0))
		else $error("low byte state entered out of order");

endmodule

@@ tb/udvm_operand_decoder_unit_tb.sv @@
// Testbench for the UDVM operand decoder: planned memory writes, operand decodes and a checker.
`timescale 1ns / 1ps

module udvm_operand_decoder_unit_tb;

	import udvmod_pkg::*;

	localparam int unsigned MEM_SIZE = MEM_BYTES_DEF;
	localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] FUNC_UNUSED_LAST = 3'd7;
	localparam int ITEM_TARGET = 1750;
	localparam int IDLE_PERCENT = 31;
	localparam int CALM_START = 4000;
	localparam int CALM_END = 7000;
	localparam int HOLD_AFTER_WORDS = 300;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] exec_pointer;
		logic [15:0] instr_address;
		logic [15:0] write_address;
		logic [7:0]  write_byte;
	} operand_word_t;

	typedef struct packed {
		logic [15:0] value;
		logic [15:0] next_ptr;
		logic        bad;
	} operand_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  func = '0;
	logic [15:0] exec_pointer = '0;
	logic [15:0] instr_address = '0;
	logic [15:0] write_address = '0;
	logic [7:0]  write_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] decoded_value;
	logic [15:0] next_pointer;
	logic        invalid_operand;

	// Memory image as the generator plans it, and which bytes have been written.
	bit [7:0] plan_image [0:MEM_SIZE-1];
	bit       plan_written [0:MEM_SIZE-1];
	// Memory image of the predictor, updated as write words are accepted.
	bit [7:0] decoder_image [0:MEM_SIZE-1];

	operand_word_t   pending_words[$];
	operand_result_t expected_results[$];
	operand_word_t   drive_word;
	operand_result_t want;

	int  n_planned = 0;
	int  n_accepted = 0;
	int  n_errors = 0;
	int  cyc = 0;
	logic hold_off = 1'b0;
	logic calm;

	assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

	udvm_operand_decoder_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.exec_pointer(exec_pointer),
		.instr_address(instr_address),
		.write_address(write_address),
		.write_byte(write_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.decoded_value(decoded_value),
		.next_pointer(next_pointer),
		.invalid_operand(invalid_operand)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned mem_idx(input logic [15:0] addr);
		return addr % MEM_SIZE;
	endfunction

	function automatic logic [15:0] decoder_word(input logic [15:0] addr);
		logic [15:0] addr_next;
		addr_next = addr + 16'd1;
		return {decoder_image[mem_idx(addr)], decoder_image[mem_idx(addr_next)]};
	endfunction

	function automatic logic [15:0] planned_word(input logic [15:0] addr);
		logic [15:0] addr_next;
		addr_next = addr + 16'd1;
		return {plan_image[mem_idx(addr)], plan_image[mem_idx(addr_next)]};
	endfunction

	// Works out the result of one accepted word and applies its memory write.
	function automatic operand_result_t decode_operand(input operand_word_t w);
		operand_result_t r;
		logic [7:0]  b;
		logic [15:0] v;
		logic [15:0] len;
		b = decoder_image[mem_idx(w.exec_pointer)];
		v = '0;
		len = '0;
		r.bad = 1'b0;
		case (w.func)
			FUNC_LITERAL, FUNC_REFERENCE: begin
				if (b[7:6] == 2'b11) begin
					// The three-byte form ignores the low bits of the first byte and is never scaled.
					v = decoder_word(w.exec_pointer + 16'd1);
					len = 16'd3;
				end else begin
					if (b[7]) begin
						v = decoder_word(w.exec_pointer) & 16'h3fff;
						len = 16'd2;
					end else begin
						v = {9'd0, b[6:0]};
						len = 16'd1;
					end
					if (w.func == FUNC_REFERENCE)
						v = v << 1;
				end
			end
			FUNC_MULTITYPE, FUNC_ADDRESS: begin
				if (b < 8'h40) begin
					v = {8'd0, b};
					len = 16'd1;
				end else if (b < 8'h80) begin
					v = decoder_word({9'd0, b[5:0], 1'b0});
					len = 16'd1;
				end else if (b == 8'h80) begin
					v = decoder_word(w.exec_pointer + 16'd1);
					len = 16'd3;
				end else if (b == 8'h81) begin
					v = decoder_word(decoder_word(w.exec_pointer + 16'd1));
					len = 16'd3;
				end else if (b < 8'h86) begin
					r.bad = 1'b1;
				end else if (b < 8'h88) begin
					v = 16'd1 << (int'(b[0]) + 6);
					len = 16'd1;
				end else if (b < 8'h90) begin
					v = 16'd1 << (int'(b[2:0]) + 8);
					len = 16'd1;
				end else if (b < 8'ha0) begin
					v = 16'hf000 | (decoder_word(w.exec_pointer) & 16'h0fff);
					len = 16'd2;
				end else if (b < 8'hc0) begin
					v = decoder_word(w.exec_pointer) & 16'h1fff;
					len = 16'd2;
				end else if (b < 8'he0) begin
					v = decoder_word(decoder_word(w.exec_pointer) & 16'h1fff);
					len = 16'd2;
				end else begin
					v = {11'h7ff, b[4:0]};
					len = 16'd1;
				end
				if (!r.bad && w.func == FUNC_ADDRESS)
					v = v + w.instr_address;
			end
			FUNC_WRITE: begin
				decoder_image[mem_idx(w.write_address)] = w.write_byte;
			end
			default: begin
			end
		endcase
		r.value = v;
		r.next_ptr = w.exec_pointer + len;
		return r;
	endfunction

	task automatic push_word(input logic [2:0] f, input logic [15:0] ep, input logic [15:0] ia,
			input logic [15:0] wa, input logic [7:0] wb);
		operand_word_t w;
		w.func = f;
		w.exec_pointer = ep;
		w.instr_address = ia;
		w.write_address = wa;
		w.write_byte = wb;
		pending_words.push_back(w);
		n_planned++;
	endtask

	task automatic plan_write(input logic [15:0] addr, input logic [7:0] data);
		plan_image[mem_idx(addr)] = data;
		plan_written[mem_idx(addr)] = 1'b1;
		push_word(FUNC_WRITE, 16'($urandom), 16'($urandom), addr, data);
	endtask

	// Bytes the operand reads indirectly are written only if nothing is there yet.
	task automatic plan_touch(input logic [15:0] addr);
		if (!plan_written[mem_idx(addr)])
			plan_write(addr, 8'($urandom));
	endtask

	// Writes every byte the operand will read, then queues the operand itself.
	task automatic plan_operand(input logic [2:0] f, input logic [15:0] ep, input logic [15:0] ia,
			input logic [7:0] b0);
		logic [15:0] p;
		plan_write(ep, b0);
		case (f)
			FUNC_LITERAL, FUNC_REFERENCE: begin
				if (b0 >= 8'hc0) begin
					plan_write(ep + 16'd1, 8'($urandom));
					plan_write(ep + 16'd2, 8'($urandom));
				end else if (b0[7]) begin
					plan_write(ep + 16'd1, 8'($urandom));
				end
			end
			FUNC_MULTITYPE, FUNC_ADDRESS: begin
				if (b0 >= 8'h40 && b0 < 8'h80) begin
					p = {9'd0, b0[5:0], 1'b0};
					plan_touch(p);
					plan_touch(p + 16'd1);
				end else if (b0 == 8'h80 || b0 == 8'h81) begin
					plan_write(ep + 16'd1, 8'($urandom));
					plan_write(ep + 16'd2, 8'($urandom));
					if (b0 == 8'h81) begin
						p = planned_word(ep + 16'd1);
						plan_touch(p);
						plan_touch(p + 16'd1);
					end
				end else if (b0 >= 8'h90 && b0 < 8'he0) begin
					plan_write(ep + 16'd1, 8'($urandom));
					if (b0 >= 8'hc0) begin
						p = planned_word(ep) & 16'h1fff;
						plan_touch(p);
						plan_touch(p + 16'd1);
					end
				end
			end
			default: begin
			end
		endcase
		push_word(f, ep, ia, 16'($urandom), 8'($urandom));
	endtask

	function automatic logic [15:0] pick_pointer();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return 16'hffff - 16'($urandom_range(2));
		if (r < 10)
			return 16'($urandom_range(3));
		return 16'($urandom);
	endfunction

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Driver: predicts each accepted word, then offers the next one unless it idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(decode_operand({func, exec_pointer, instr_address,
					write_address, write_byte}));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
					drive_word = pending_words.pop_front();
					func <= drive_word.func;
					exec_pointer <= drive_word.exec_pointer;
					instr_address <= drive_word.instr_address;
					write_address <= drive_word.write_address;
					write_byte <= drive_word.write_byte;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					n_errors++;
					if (n_errors <= REPORT_LIMIT)
						$display("unexpected result word: value %h next %h invalid %b",
							decoded_value, next_pointer, invalid_operand);
				end else begin
					want = expected_results.pop_front();
					if (decoded_value !== want.value || next_pointer !== want.next_ptr ||
							invalid_operand !== want.bad) begin
						n_errors++;
						if (n_errors <= REPORT_LIMIT)
							$display("mismatch at cycle %0d: value %h/%h next %h/%h invalid %b/%b (exp/got)",
								cyc, want.value, decoded_value, want.next_ptr, next_pointer,
								want.bad, invalid_operand);
					end
				end
			end
			out_stall <= hold_off || (!calm && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// One long receiver hold-off so the block backs up into its input.
	initial begin
		while (n_accepted < HOLD_AFTER_WORDS)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int pick;

		// Directed operands: boundary first bytes of several forms, wraps, bad codes and an unused code.
		plan_operand(FUNC_LITERAL, 16'h0000, 16'h0000, 8'h00);
		plan_operand(FUNC_LITERAL, 16'h0010, 16'hffff, 8'h7f);
		plan_operand(FUNC_LITERAL, 16'hfffe, 16'h0000, 8'hff);
		plan_operand(FUNC_REFERENCE, 16'h0020, 16'h0000, 8'h7f);
		plan_operand(FUNC_REFERENCE, 16'hffff, 16'h0000, 8'hbf);
		plan_operand(FUNC_REFERENCE, 16'h0030, 16'h0000, 8'hc0);
		plan_operand(FUNC_MULTITYPE, 16'h0040, 16'h0000, 8'h82);
		plan_operand(FUNC_ADDRESS, 16'h0041, 16'h1234, 8'h85);
		plan_operand(FUNC_MULTITYPE, 16'hffff, 16'h0000, 8'h81);
		plan_operand(FUNC_MULTITYPE, 16'h0050, 16'h0000, 8'h7f);
		plan_operand(FUNC_MULTITYPE, 16'h0052, 16'h0000, 8'hdf);
		plan_operand(FUNC_ADDRESS, 16'h0054, 16'hffff, 8'hff);
		plan_operand(FUNC_ADDRESS, 16'h0055, 16'h8000, 8'h8f);
		plan_operand(FUNC_UNUSED_LAST, 16'hffff, 16'hffff, 8'h00);
		plan_write(16'hffff, 8'hff);

		while (n_planned < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 8)
				plan_write(16'($urandom), 8'($urandom));
			else if (pick < 12)
				push_word(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)), 16'($urandom),
					16'($urandom), 16'($urandom), 8'($urandom));
			else
				plan_operand(3'($urandom_range(FUNC_ADDRESS)), pick_pointer(), 16'($urandom),
					8'($urandom));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		n_errors += expected_results.size();

		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/udvmod_pkg.sv
rtl/udvmod_mem.sv
rtl/udvm_operand_decoder_unit.sv
tb/udvm_operand_decoder_unit_tb.sv
